[rtl/tlb_pkg.sv]
// Shared types and constants for the fully associative TLB.
// Holds the request record that travels along the chain of entry cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlb_pkg;

    localparam int ADDR_W   = 32;
    localparam int PAGE_W   = 20;
    localparam int OFFSET_W = 12;
    localparam int INDEX_W  = 6;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                opcode;
        logic                enable;
        logic [ADDR_W-1:0]   vaddr;
        logic [INDEX_W-1:0]  index;
        logic                e_valid;
        logic [PAGE_W-1:0]   e_page;
        logic [PAGE_W-1:0]   e_frame;
        logic                hit;
        logic [PAGE_W-1:0]   frame;
    } tlb_req_t;

endpackage

`default_nettype wire

[rtl/tlb_cell.sv]
// One TLB entry cell: stores a valid bit, page and frame for one slot.
// Updates its slot on a matching write request, resolves a lookup if no
// earlier cell hit, and registers the request for the next cell. Uses tlb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlb_cell
    import tlb_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire tlb_req_t req_in,
    output tlb_req_t      req_out
);

    localparam bit WRITABLE = (CELL_INDEX < (1 << INDEX_W));
    localparam logic [INDEX_W-1:0] CELL_CODE = INDEX_W'(CELL_INDEX);

    logic              slot_valid_reg;
    logic [PAGE_W-1:0] slot_page_reg;
    logic [PAGE_W-1:0] slot_frame_reg;
    tlb_req_t          req_reg;
    tlb_req_t          req_next;
    logic              write_sel;
    logic              match;

    assign write_sel = WRITABLE && req_in.valid && (req_in.opcode == OP_WRITE)
                       && (req_in.index == CELL_CODE);

    assign match = req_in.valid && (req_in.opcode == OP_LOOKUP) && !req_in.hit
                   && slot_valid_reg
                   && (slot_page_reg == req_in.vaddr[ADDR_W-1:OFFSET_W]);

    always_comb
    begin
        req_next = req_in;
        if (match)
        begin
            req_next.hit   = 1'b1;
            req_next.frame = slot_frame_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
        end
        else if (write_sel)
        begin
            slot_valid_reg <= req_in.e_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_sel)
        begin
            slot_page_reg  <= req_in.e_page;
            slot_frame_reg <= req_in.e_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= '0;
        end
        else
        begin
            req_reg <= req_next;
        end
    end

    assign req_out = req_reg;

endmodule

`default_nettype wire

[rtl/fully_associative_tlb_lookup.sv]
// Top level of the fully associative TLB with 4 KiB pages.
// Builds a chain of tlb_cell entries and the result register. Uses tlb_pkg.
//
// A request is taken at a rising edge with start high and busy low; busy is
// never raised, so a new request may be issued in every cycle. Opcode selects
// a lookup of virtual_address or a write of one entry (entry_index,
// entry_valid, entry_page, entry_frame). Each request walks the chain of
// ENTRIES cells, one cell per cycle, so writes and lookups keep their order.
// The result appears on physical_address, fault and miss_flag with done high
// for one cycle, from the result register behind the last cell of the chain.
// Throughput is one request per cycle. A write returns an all-zero result.
// translate_enable is written through translate_enable_we and
// translate_enable_wdata; the user must do so only while no request is in
// flight, as the block itself does not enforce this. Reset clears all valid
// bits, the enable and the chain; the receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none

module fully_associative_tlb_lookup
    import tlb_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               opcode,
    input  wire logic [ADDR_W-1:0]  virtual_address,
    input  wire logic [INDEX_W-1:0] entry_index,
    input  wire logic               entry_valid,
    input  wire logic [PAGE_W-1:0]  entry_page,
    input  wire logic [PAGE_W-1:0]  entry_frame,
    input  wire logic               translate_enable_we,
    input  wire logic               translate_enable_wdata,
    output logic                    done,
    output logic [ADDR_W-1:0]       physical_address,
    output logic                    fault,
    output logic                    miss_flag
);

    logic              translate_enable_reg;
    tlb_req_t          chain [ENTRIES+1];
    tlb_req_t          tail;
    logic              done_reg;
    logic [ADDR_W-1:0] pa_reg;
    logic              fault_reg;
    logic              miss_reg;
    logic [ADDR_W-1:0] pa_next;
    logic              fault_next;
    logic              miss_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            translate_enable_reg <= 1'b0;
        end
        else if (translate_enable_we)
        begin
            translate_enable_reg <= translate_enable_wdata;
        end
    end

    always_comb
    begin
        chain[0]         = '0;
        chain[0].valid   = start && !busy;
        chain[0].opcode  = opcode;
        chain[0].enable  = translate_enable_reg;
        chain[0].vaddr   = virtual_address;
        chain[0].index   = entry_index;
        chain[0].e_valid = entry_valid;
        chain[0].e_page  = entry_page;
        chain[0].e_frame = entry_frame;
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        tlb_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .req_in  (chain[g]),
            .req_out (chain[g+1])
        );
    end

    assign tail = chain[ENTRIES];

    always_comb
    begin
        pa_next    = '0;
        fault_next = 1'b0;
        miss_next  = 1'b0;
        if (tail.opcode == OP_LOOKUP)
        begin
            if (!tail.enable)
            begin
                pa_next   = tail.vaddr;
                miss_next = 1'b1;
            end
            else if (tail.hit)
            begin
                pa_next = {tail.frame, tail.vaddr[OFFSET_W-1:0]};
            end
            else
            begin
                fault_next = 1'b1;
                miss_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            pa_reg    <= pa_next;
            fault_reg <= fault_next;
            miss_reg  <= miss_next;
        end
    end

    assign done             = done_reg;
    assign physical_address = pa_reg;
    assign fault            = fault_reg;
    assign miss_flag        = miss_reg;

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, ENTRIES + 1))
        else $error("result without a request");

    a_fault_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && fault) |-> (miss_flag && (physical_address == '0)))
        else $error("fault without miss or with nonzero address");

    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !miss_flag) |-> !fault)
        else $error("hit reported with fault");

    a_write_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tail.valid && (tail.opcode == OP_WRITE)) |=>
            (done && !fault && !miss_flag && (physical_address == '0)))
        else $error("write request gave nonzero result");

endmodule

`default_nettype wire
